@@ src/rpip_pkg.sv @@
// ----------------------------------------------------------------------------
// rpip_pkg
// Types, character codes and small helpers for the radix-prefixed integer
// parser.
// ----------------------------------------------------------------------------
package rpip_pkg;

   typedef enum logic [10:0] {
      PH_START  = 11'b000_0000_0001,
      PH_PFX0   = 11'b000_0000_0010,
      PH_PFX1   = 11'b000_0000_0100,
      PH_PFX2   = 11'b000_0000_1000,
      PH_AFTER  = 11'b000_0001_0000,
      PH_EMPTY  = 11'b000_0010_0000,
      PH_WS     = 11'b000_0100_0000,
      PH_SIGN   = 11'b000_1000_0000,
      PH_ZERO16 = 11'b001_0000_0000,
      PH_X      = 11'b010_0000_0000,
      PH_DIG    = 11'b100_0000_0000
   } phase_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5a;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7a;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_LR    = 8'h72;

   localparam logic [6:0] RADIX_MIN = 7'd2;
   localparam logic [6:0] RADIX_MAX = 7'd36;
   localparam logic [6:0] RADIX_OCT = 7'd8;
   localparam logic [6:0] RADIX_DEC = 7'd10;
   localparam logic [6:0] RADIX_HEX = 7'd16;
   localparam logic [6:0] DIGIT_BAD = 7'd99;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [6:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (is_dec(c)) begin
         d = c - CH_ZERO;
      end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
         d = c - CH_LA + 8'd10;
      end else if ((c >= CH_UA) && (c <= CH_UZ)) begin
         d = c - CH_UA + 8'd10;
      end else begin
         d = {1'b0, DIGIT_BAD};
      end
      return d[6:0];
   endfunction

endpackage

@@ src/radix_prefixed_integer_parser_core.sv @@
// ----------------------------------------------------------------------------
// radix_prefixed_integer_parser_core: one character word per cycle unless a
// pending result is held by rsp_tready, result in the cycle after the terminating
// zero (one multiply-add by the radix between input and state registers)
// synchronous reset returns to start of string with no result pending
// ----------------------------------------------------------------------------
module radix_prefixed_integer_parser_core #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // value
   output logic [1:0]  rsp_tuser    // overflow (bit 1), ok (bit 0)
);

   localparam int VW = VALUE_WIDTH;
   localparam int PW = VALUE_WIDTH + 7;
   localparam logic [VW-1:0] TOP  = {1'b1, {(VW-1){1'b0}}};
   localparam logic [VW-1:0] MAXP = {1'b0, {(VW-1){1'b1}}};

   rpip_pkg::phase_type phase_ff, phase_in;
   logic          negative_ff, negative_in;
   logic          inner_neg_ff, inner_neg_in;
   logic [6:0]    radix_ff, radix_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic          sat_ff, sat_in;
   logic [7:0]    held0_ff, held0_in;
   logic [7:0]    held1_ff, held1_in;
   logic          rejected_ff, rejected_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic [7:0]    ch;
   logic          accept;
   logic [3:0]    d0, d1;
   logic          fb_oct;
   logic [6:0]    fb_radix;
   logic [6:0]    dec2;
   logic [VW-1:0] fb1_acc, fb2_acc;
   logic          fb2_rej;

   rpip_pkg::phase_type b_phase;
   logic [6:0]    b_radix;
   logic [VW-1:0] b_acc;
   logic          b_rej;
   logic          do_body;
   logic          first_d, more_d;
   logic [6:0]    dv;
   logic [VW-1:0] limit;
   logic [PW-1:0] prod;

   rpip_pkg::phase_type t_phase;
   logic [VW-1:0] t_acc;
   logic          t_rej;
   logic          t_ok;
   logic [VW-1:0] t_val;
   logic          t_ovf;

   assign ch         = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // held prefix digits, decimal, replayed when the prefix turns out not to be one
   assign d0       = held0_ff[3:0];
   assign d1       = held1_ff[3:0];
   assign fb_oct   = (d0 == 4'd0);
   assign fb_radix = fb_oct ? rpip_pkg::RADIX_OCT : rpip_pkg::RADIX_DEC;
   assign dec2     = 7'(d0) * 7'd10 + 7'(d1);
   assign fb1_acc  = VW'(d0);
   assign fb2_acc  = fb_oct ? VW'(d1) : VW'(dec2);
   assign fb2_rej  = fb_oct && d1[3];

   assign dv    = rpip_pkg::digit_value(ch);
   assign limit = inner_neg_ff ? TOP : MAXP;
   assign prod  = PW'(b_acc) * PW'(b_radix) + PW'(dv);

   always_comb begin
      phase_in     = phase_ff;
      negative_in  = negative_ff;
      inner_neg_in = inner_neg_ff;
      radix_in     = radix_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      rejected_in  = rejected_ff;
      b_phase      = phase_ff;
      b_radix      = radix_ff;
      b_acc        = acc_ff;
      b_rej        = rejected_ff;
      do_body      = 1'b0;
      first_d      = 1'b0;
      more_d       = 1'b0;
      t_phase      = phase_ff;
      t_acc        = acc_ff;
      t_rej        = rejected_ff;
      t_ok         = 1'b0;
      t_val        = '0;
      t_ovf        = 1'b0;

      // end of string
      if (!rejected_ff && (phase_ff == rpip_pkg::PH_PFX1)) begin
         t_phase = rpip_pkg::PH_DIG;
         t_acc   = fb1_acc;
      end else if (!rejected_ff && (phase_ff == rpip_pkg::PH_PFX2)) begin
         t_phase = rpip_pkg::PH_DIG;
         t_acc   = fb2_acc;
         t_rej   = fb2_rej;
      end
      t_ok = !t_rej && ((t_phase == rpip_pkg::PH_START) || (t_phase == rpip_pkg::PH_PFX0) ||
                        (t_phase == rpip_pkg::PH_AFTER) || (t_phase == rpip_pkg::PH_EMPTY) ||
                        (t_phase == rpip_pkg::PH_ZERO16) || (t_phase == rpip_pkg::PH_DIG));
      if (t_ok) begin
         t_ovf = sat_ff;
         if (negative_ff && inner_neg_ff) begin
            if (t_acc >= TOP) begin
               t_val = MAXP;
               t_ovf = 1'b1;
            end else begin
               t_val = t_acc;
            end
         end else if (negative_ff || inner_neg_ff) begin
            t_val = '0 - t_acc;
         end else begin
            t_val = t_acc;
         end
      end

      // prefix stage
      if (accept && (ch != rpip_pkg::CH_NUL) && !rejected_ff) begin
         if ((phase_ff == rpip_pkg::PH_START) && rpip_pkg::is_sign(ch)) begin
            negative_in = (ch == rpip_pkg::CH_MINUS);
            phase_in    = rpip_pkg::PH_PFX0;
         end else if ((phase_ff == rpip_pkg::PH_START) || (phase_ff == rpip_pkg::PH_PFX0)) begin
            if (rpip_pkg::is_dec(ch)) begin
               held0_in = ch;
               phase_in = rpip_pkg::PH_PFX1;
            end else begin
               b_radix = rpip_pkg::RADIX_DEC;
               b_phase = rpip_pkg::PH_EMPTY;
               do_body = 1'b1;
            end
         end else if (phase_ff == rpip_pkg::PH_PFX1) begin
            if (fb_oct && (ch == rpip_pkg::CH_LX)) begin
               radix_in = rpip_pkg::RADIX_HEX;
               phase_in = rpip_pkg::PH_AFTER;
            end else if (ch == rpip_pkg::CH_LR) begin
               radix_in    = 7'(d0);
               rejected_in = (7'(d0) < rpip_pkg::RADIX_MIN);
               phase_in    = rpip_pkg::PH_AFTER;
            end else if (rpip_pkg::is_dec(ch)) begin
               held1_in = ch;
               phase_in = rpip_pkg::PH_PFX2;
            end else begin
               b_radix = fb_radix;
               b_acc   = fb1_acc;
               b_phase = rpip_pkg::PH_DIG;
               do_body = 1'b1;
            end
         end else if (phase_ff == rpip_pkg::PH_PFX2) begin
            if (ch == rpip_pkg::CH_LR) begin
               radix_in    = dec2;
               rejected_in = (dec2 < rpip_pkg::RADIX_MIN) || (dec2 > rpip_pkg::RADIX_MAX);
               phase_in    = rpip_pkg::PH_AFTER;
            end else begin
               b_radix = fb_radix;
               b_acc   = fb2_acc;
               b_phase = rpip_pkg::PH_DIG;
               b_rej   = fb2_rej;
               do_body = 1'b1;
            end
         end else if (phase_ff == rpip_pkg::PH_AFTER) begin
            if ((radix_ff != rpip_pkg::RADIX_DEC) && rpip_pkg::is_sign(ch)) begin
               rejected_in = 1'b1;
            end else begin
               b_phase = rpip_pkg::PH_EMPTY;
               do_body = 1'b1;
            end
         end else begin
            do_body = 1'b1;
         end
      end

      // body stage, strtol rules
      if (do_body) begin
         phase_in    = b_phase;
         radix_in    = b_radix;
         acc_in      = b_acc;
         rejected_in = b_rej;
         if (!b_rej) begin
            unique case (b_phase)
               rpip_pkg::PH_EMPTY, rpip_pkg::PH_WS: begin
                  if (rpip_pkg::is_space(ch)) begin
                     phase_in = rpip_pkg::PH_WS;
                  end else if (rpip_pkg::is_sign(ch)) begin
                     inner_neg_in = (ch == rpip_pkg::CH_MINUS);
                     phase_in     = rpip_pkg::PH_SIGN;
                  end else begin
                     first_d = 1'b1;
                  end
               end
               rpip_pkg::PH_SIGN: begin
                  first_d = 1'b1;
               end
               rpip_pkg::PH_ZERO16: begin
                  if ((ch == rpip_pkg::CH_LX) || (ch == rpip_pkg::CH_UX)) begin
                     phase_in = rpip_pkg::PH_X;
                  end else begin
                     more_d = 1'b1;
                  end
               end
               rpip_pkg::PH_X, rpip_pkg::PH_DIG: begin
                  more_d = 1'b1;
               end
               default: begin
                  rejected_in = 1'b1;
               end
            endcase
            if (first_d || more_d) begin
               priority if (dv >= b_radix) begin
                  rejected_in = 1'b1;
               end else if (first_d && (b_radix == rpip_pkg::RADIX_HEX) && (dv == 7'd0)) begin
                  phase_in = rpip_pkg::PH_ZERO16;
               end else if (b_radix < rpip_pkg::RADIX_MIN) begin
                  rejected_in = 1'b1;
               end else if (prod > PW'(limit)) begin
                  acc_in   = limit;
                  sat_in   = 1'b1;
                  phase_in = rpip_pkg::PH_DIG;
               end else begin
                  acc_in   = prod[VW-1:0];
                  phase_in = rpip_pkg::PH_DIG;
               end
            end
         end
      end

      if (accept && (ch == rpip_pkg::CH_NUL)) begin
         phase_in     = rpip_pkg::PH_START;
         negative_in  = 1'b0;
         inner_neg_in = 1'b0;
         radix_in     = rpip_pkg::RADIX_DEC;
         acc_in       = '0;
         sat_in       = 1'b0;
         held0_in     = 8'd0;
         held1_in     = 8'd0;
         rejected_in  = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept && (ch == rpip_pkg::CH_NUL)) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = 64'($signed(t_val));
         rsp_ok_in    = t_ok;
         rsp_ovf_in   = t_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rpip_pkg::PH_START;
         negative_ff  <= 1'b0;
         inner_neg_ff <= 1'b0;
         radix_ff     <= rpip_pkg::RADIX_DEC;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         held0_ff     <= 8'd0;
         held1_ff     <= 8'd0;
         rejected_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         inner_neg_ff <= inner_neg_in;
         radix_ff     <= radix_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         held0_ff     <= held0_in;
         held1_ff     <= held1_in;
         rejected_ff  <= rejected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_ok_ff};

endmodule
